// ===== rtl/fcfs_pkg.sv =====
`default_nettype none

package fcfs_pkg;

  // Fixed field widths of the job channel
  localparam int JOB_ID_W   = 8;
  localparam int SVC_W      = 16;
  localparam int DL_W       = 24;
  localparam int OUT_TIME_W = 32;

  // Input item function codes
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Result kind codes
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/fcfs_queue_ram.sv =====
`default_nettype none

module fcfs_queue_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, write-first when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fcfs_job_scheduler_core.sv =====
`default_nettype none
// First-come-first-served job scheduler.
// Input channel (in_*): each beat is either a job arrival (in_func = arrival,
// with id, service time and deadline) or one scheduler tick. Arrivals are
// time-stamped and queued; a full queue rejects the arrival with a result.
// On a tick a head job with no service left is retired with a result that
// carries its turnaround, wait and deadline flag; then the head job is
// serviced for one tick and the time counter advances.
// Output channel (out_*): zero or one result beat per input beat.
// Latency: a result is presented the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while in_ready is high. The queue
// memory has one write port (tail) and one registered read port that always
// prefetches the next head, so no arrival or tick waits on a memory read.
// Stall: the result register is the only buffer; while it holds a beat and
// out_ready is low, in_ready is low. Otherwise in_ready stays high.
// Reset: in_ready is low while rst_n is low. Queue empty, pointers, service
// counter and time at zero. The queue memory is not cleared; entries are
// only read after they are written.
module fcfs_job_scheduler_core
  import fcfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [JOB_ID_W-1:0]   in_job_id,
  input  wire logic [SVC_W-1:0]      in_service_time,
  input  wire logic [DL_W-1:0]       in_deadline,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [JOB_ID_W-1:0]        out_done_job_id,
  output logic [OUT_TIME_W-1:0]      out_turnaround_time,
  output logic [OUT_TIME_W-1:0]      out_wait_time,
  output logic                       out_deadline_met
);

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = JOB_ID_W + TIME_WIDTH + SVC_W + DL_W;
  localparam int CMPW = (TIME_WIDTH > DL_W) ? TIME_WIDTH : DL_W;

  // Queue control state
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [SVC_W-1:0]      rem_r, rem_nxt;
  logic                  rem_load_r, rem_load_nxt;   // remaining = head svc - 1
  logic [TIME_WIDTH-1:0] time_r, time_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r;
  logic [JOB_ID_W-1:0]   out_id_r;
  logic [OUT_TIME_W-1:0] out_ta_r;
  logic [OUT_TIME_W-1:0] out_wt_r;
  logic                  out_met_r;

  // Head entry from the queue memory
  logic [EW-1:0]         wr_data;
  logic [EW-1:0]         head_q;
  logic [JOB_ID_W-1:0]   head_id;
  logic [TIME_WIDTH-1:0] head_arr;
  logic [SVC_W-1:0]      head_svc;
  logic [DL_W-1:0]       head_dl;

  logic                  in_fire, is_arr, is_tick;
  logic                  full, nonempty;
  logic                  arrive_ok, reject, retire;
  logic [SVC_W-1:0]      svc_fix, eff_rem;
  logic [TIME_WIDTH-1:0] ta, wt;

  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign is_arr    = (in_func == FUNC_ARRIVAL);
  assign is_tick   = (in_func == FUNC_TICK);
  assign full      = (count_r == CNTW'(QUEUE_DEPTH));
  assign nonempty  = (count_r != '0);
  assign svc_fix   = (in_service_time == '0) ? SVC_W'(1) : in_service_time;

  assign {head_id, head_arr, head_svc, head_dl} = head_q;
  assign eff_rem   = rem_load_r ? (head_svc - SVC_W'(1)) : rem_r;

  assign arrive_ok = in_fire && is_arr && !full;
  assign reject    = in_fire && is_arr && full;
  assign retire    = in_fire && is_tick && nonempty && (eff_rem == '0);

  // Timing figures of the retiring head job
  assign ta = time_r - head_arr;
  assign wt = ta - TIME_WIDTH'(head_svc);

  assign wr_data = {in_job_id, time_r, svc_fix, in_deadline};

  // Next-state logic for pointers, count, service counter and time
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    rem_load_nxt = rem_load_r;
    time_nxt     = time_r;

    if (arrive_ok) begin
      tail_nxt  = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PW'(1);
      count_nxt = count_r + CNTW'(1);
      if (!nonempty) begin
        rem_nxt      = svc_fix;
        rem_load_nxt = 1'b0;
      end
    end

    if (in_fire && is_tick) begin
      time_nxt = time_r + TIME_WIDTH'(1);
      if (retire) begin
        head_nxt  = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + PW'(1);
        count_nxt = count_r - CNTW'(1);
        // new head gets its service loaded and one tick taken off at once
        if (count_r > CNTW'(1)) begin
          rem_load_nxt = 1'b1;
        end else begin
          rem_nxt      = '0;
          rem_load_nxt = 1'b0;
        end
      end else if (nonempty) begin
        rem_nxt      = eff_rem - SVC_W'(1);
        rem_load_nxt = 1'b0;
      end
    end
  end

  // Result register hand-off
  always_comb begin
    if (reject || retire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      rem_load_r  <= 1'b0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      rem_load_r  <= rem_load_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (reject) begin
      out_kind_r <= KIND_REJECT;
      out_id_r   <= in_job_id;
      out_ta_r   <= '0;
      out_wt_r   <= '0;
      out_met_r  <= 1'b0;
    end else if (retire) begin
      out_kind_r <= KIND_DONE;
      out_id_r   <= head_id;
      out_ta_r   <= OUT_TIME_W'(ta);
      out_wt_r   <= OUT_TIME_W'(wt);
      out_met_r  <= (CMPW'(ta) <= CMPW'(head_dl));
    end
  end

  // Queue storage; read address follows the next head so head_q is current
  fcfs_queue_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (arrive_ok),
    .wr_addr (tail_r),
    .wr_data (wr_data),
    .rd_addr (head_nxt),
    .rd_data (head_q)
  );

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_done_job_id     = out_id_r;
  assign out_turnaround_time = out_ta_r;
  assign out_wait_time       = out_wt_r;
  assign out_deadline_met    = out_met_r;

endmodule

`default_nettype wire

// ===== rtl/fcfs_checker.sv =====
`default_nettype none

module fcfs_checker
  import fcfs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_kind,
  input wire logic [JOB_ID_W-1:0]   out_done_job_id,
  input wire logic [OUT_TIME_W-1:0] out_turnaround_time,
  input wire logic [OUT_TIME_W-1:0] out_wait_time,
  input wire logic                  out_deadline_met
);

  // Input only stalls behind a result beat that is held up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a blocked result beat");

  // A rejection carries no timing figures
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_REJECT)) |->
      ((out_turnaround_time == '0) && (out_wait_time == '0) && !out_deadline_met))
    else $error("rejection beat with nonzero timing fields");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_done_job_id) &&
       $stable(out_turnaround_time) && $stable(out_wait_time) &&
       $stable(out_deadline_met)))
    else $error("result beat changed while stalled");

endmodule

bind fcfs_job_scheduler_core fcfs_checker u_fcfs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_kind            (out_kind),
  .out_done_job_id     (out_done_job_id),
  .out_turnaround_time (out_turnaround_time),
  .out_wait_time       (out_wait_time),
  .out_deadline_met    (out_deadline_met)
);

`default_nettype wire

// ===== test/tb_fcfs_job_scheduler_core.sv =====
`timescale 1ns / 1ps

module tb_fcfs_job_scheduler_core;
  import fcfs_pkg::*;

  localparam int DEPTH      = 64;
  localparam int TWIDTH     = 32;
  localparam int MAX_CYCLES = 1000000;
  localparam int TAIL_WAIT  = 20;
  localparam int RAND_BEATS = 700;

  // One result beat as the block should present it
  typedef struct packed {
    logic                  kind;
    logic [JOB_ID_W-1:0]   job_id;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [OUT_TIME_W-1:0] wait_t;
    logic                  met;
  } sched_result_t;

  // Shadow FCFS queue plus the list of retirements/rejections still owed
  class job_ledger #(int SLOTS = 64);
    logic [JOB_ID_W-1:0]   slot_id[SLOTS];
    logic [TWIDTH-1:0]     slot_arrival[SLOTS];
    logic [SVC_W-1:0]      slot_svc[SLOTS];
    logic [DL_W-1:0]       slot_dl[SLOTS];
    int unsigned           head, tail, count;
    logic [SVC_W-1:0]      remaining;
    logic [TWIDTH-1:0]     now;
    sched_result_t         owed[$];
    int                    errors, n_arrival, n_tick, n_reject, n_done, n_met;

    function new();
      head = 0; tail = 0; count = 0; remaining = '0; now = '0;
      errors = 0; n_arrival = 0; n_tick = 0; n_reject = 0; n_done = 0; n_met = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Advance the shadow scheduler by one accepted input beat
    function void note_beat(logic func, logic [JOB_ID_W-1:0] id,
                            logic [SVC_W-1:0] svc_in, logic [DL_W-1:0] dl_in);
      sched_result_t     r;
      logic [SVC_W-1:0]  svc;
      logic [TWIDTH-1:0] ta;
      svc = (svc_in == '0) ? SVC_W'(1) : svc_in;
      if (func == FUNC_ARRIVAL) begin
        n_arrival++;
        if (count >= SLOTS) begin
          r = '{KIND_REJECT, id, '0, '0, 1'b0};
          owed.push_back(r);
          n_reject++;
          return;
        end
        slot_id[tail] = id;
        slot_arrival[tail] = now;
        slot_svc[tail] = svc;
        slot_dl[tail] = dl_in;
        tail = (tail + 1) % SLOTS;
        if (count == 0) remaining = svc;
        count++;
        return;
      end
      n_tick++;
      // retire the head once its service is used up
      if (count > 0 && remaining == '0) begin
        ta = now - slot_arrival[head];
        r.kind       = KIND_DONE;
        r.job_id     = slot_id[head];
        r.turnaround = OUT_TIME_W'(ta);
        r.wait_t     = OUT_TIME_W'(ta - TWIDTH'(slot_svc[head]));
        r.met        = (ta <= TWIDTH'(slot_dl[head]));
        owed.push_back(r);
        n_done++;
        if (r.met) n_met++;
        head = (head + 1) % SLOTS;
        count--;
        remaining = (count > 0) ? slot_svc[head] : '0;
      end
      if (count > 0 && remaining != '0) remaining--;
      now = now + 1'b1;
    endfunction

    // Compare one result beat with the oldest owed result
    task check_beat(sched_result_t got);
      sched_result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed (id %0d)", got.job_id));
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.job_id !== want.job_id)
        report_mismatch($sformatf("job id %0d, want %0d", got.job_id, want.job_id));
      if (got.turnaround !== want.turnaround)
        report_mismatch($sformatf("job %0d turnaround %0d, want %0d",
                                  want.job_id, got.turnaround, want.turnaround));
      if (got.wait_t !== want.wait_t)
        report_mismatch($sformatf("job %0d wait %0d, want %0d",
                                  want.job_id, got.wait_t, want.wait_t));
      if (got.met !== want.met)
        report_mismatch($sformatf("job %0d deadline flag %0b, want %0b",
                                  want.job_id, got.met, want.met));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [JOB_ID_W-1:0]   in_job_id;
  logic [SVC_W-1:0]      in_service_time;
  logic [DL_W-1:0]       in_deadline;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_kind;
  logic [JOB_ID_W-1:0]   out_done_job_id;
  logic [OUT_TIME_W-1:0] out_turnaround_time;
  logic [OUT_TIME_W-1:0] out_wait_time;
  logic                  out_deadline_met;

  job_ledger #(DEPTH) sb;
  bit  calm;
  int  n_sent;
  int  cycles;

  fcfs_job_scheduler_core #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_WIDTH (TWIDTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_job_id          (in_job_id),
    .in_service_time    (in_service_time),
    .in_deadline        (in_deadline),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_done_job_id    (out_done_job_id),
    .out_turnaround_time(out_turnaround_time),
    .out_wait_time      (out_wait_time),
    .out_deadline_met   (out_deadline_met)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("watchdog expired after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DL_W-1:0] pick_deadline();
    if ($urandom_range(0, 99) < 70) return DL_W'($urandom_range(0, 80));
    return DL_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // Result side backpressure
  always begin
    int hold;
    @(negedge clk);
    hold = pick_gap();
    if (hold > 0) begin
      out_ready <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  // Monitor: take result beats and input beats at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_beat('{out_kind, out_done_job_id, out_turnaround_time,
                        out_wait_time, out_deadline_met});
      if (in_valid && in_ready)
        sb.note_beat(in_func, in_job_id, in_service_time, in_deadline);
    end
  end

  // Drive one input beat and hold it until accepted
  task automatic send_beat(logic func, logic [JOB_ID_W-1:0] id,
                           logic [SVC_W-1:0] svc, logic [DL_W-1:0] dl);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_job_id       <= id;
    in_service_time <= svc;
    in_deadline     <= dl;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_arrival(logic [JOB_ID_W-1:0] id, logic [SVC_W-1:0] svc,
                              logic [DL_W-1:0] dl);
    send_beat(FUNC_ARRIVAL, id, svc, dl);
  endtask

  // Tick fields other than func are junk on purpose
  task automatic send_tick();
    send_beat(FUNC_TICK, JOB_ID_W'($urandom), SVC_W'($urandom), DL_W'($urandom));
  endtask

  // Typical traffic: light load with the odd long job
  task automatic run_burst();
    int len;
    logic [SVC_W-1:0] svc;
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(0, 99) < ((sb.count > 40) ? 95 : 75)) begin
        send_tick();
      end else begin
        svc = ($urandom_range(0, 99) < 95) ? SVC_W'($urandom_range(1, 3))
                                           : SVC_W'($urandom_range(7, 400));
        send_arrival(JOB_ID_W'($urandom), svc, pick_deadline());
      end
    end
  endtask

  // Fill the queue, bounce a few arrivals off it, then drain most of it
  task automatic run_flood();
    int floor_n;
    while (sb.count < DEPTH)
      send_arrival(JOB_ID_W'($urandom), SVC_W'($urandom_range(1, 2)), pick_deadline());
    repeat ($urandom_range(1, 3))
      send_arrival(JOB_ID_W'($urandom), SVC_W'($urandom_range(1, 16'hFFFF)),
                   DL_W'($urandom));
    floor_n = $urandom_range(0, 4);
    while (sb.count > floor_n) send_tick();
  endtask

  initial begin
    int floods;
    int base;
    sb = new();
    calm = 1'b0;
    n_sent = 0;
    cycles = 0;
    floods = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_TICK;
    in_job_id = '0;
    in_service_time = '0;
    in_deadline = '0;
    out_ready = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, field extremes, zero service, missed deadline
    send_tick();
    send_arrival(8'd0, 16'd0, 24'd0);
    send_arrival(8'hFF, 16'd1, 24'hFFFFFF);
    send_arrival(8'h5A, 16'd2, 24'd0);
    send_tick();
    send_tick();
    send_arrival(8'hA5, 16'd3, 24'd6);
    repeat (5) send_tick();
    send_arrival(8'h01, 16'd1, 24'd1);
    send_tick();
    send_arrival(8'h80, 16'd2, 24'd2);
    repeat (6) send_tick();

    // Random traffic with the occasional full-queue episode
    base = n_sent;
    while (n_sent - base < RAND_BEATS) begin
      if ($urandom_range(0, 99) < 15) calm = !calm;
      if (floods < 2 && $urandom_range(0, 99) < 6) begin
        run_flood();
        floods++;
      end else begin
        run_burst();
      end
    end
    calm = 1'b0;
    if (floods == 0) run_flood();

    // Long jobs parked at the end so the high service bits get exercised
    send_arrival(JOB_ID_W'($urandom), 16'hFFFF, DL_W'($urandom));
    send_arrival(JOB_ID_W'($urandom), 16'h8000, DL_W'($urandom));
    repeat (3) send_tick();
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d arrivals (%0d turned away by a full queue), %0d ticks, %0d beats total",
             sb.n_arrival, sb.n_reject, sb.n_tick, n_sent);
    $display("%0d jobs retired, %0d of them inside their deadline",
             sb.n_done, sb.n_met);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fcfs_pkg.sv
rtl/fcfs_queue_ram.sv
rtl/fcfs_job_scheduler_core.sv
rtl/fcfs_checker.sv
test/tb_fcfs_job_scheduler_core.sv
